FILE: rtl/core/ihr_pkg.sv
// Shared types and constants for the IPv4 TCP balancer header rewrite.
// Beat structs for both channels, checksum unit control, verdict and register codes.
`timescale 1ns / 1ps
`default_nettype none
package ihr_pkg;

	localparam int HDR_BYTES = 34;
	localparam int ETH_BYTES = 14;
	localparam int IDX_W     = 6;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int SUM_W     = 20;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;

	localparam logic [1:0] VERDICT_ABORT = 2'd0;
	localparam logic [1:0] VERDICT_PASS  = 2'd1;
	localparam logic [1:0] VERDICT_TX    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NET_PREFIX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIENT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKEND_A  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACKEND_B  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LB         = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
		logic       backend_pick;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] verdict;
		logic       last_of_run;
	} out_beat_t;

	// control word for the shared checksum accumulator
	typedef struct packed {
		logic clr;
		logic add;
		logic hi;
		logic fold;
	} csum_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/ipv4_tcp_balancer_header_rewrite.sv
// Top level of the IPv4 TCP balancer header rewrite.
// Uses ihr_pkg (types, codes) and ihr_csum_acc (shared checksum accumulator).
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data) carries one frame byte per beat,
//    with end_of_frame on the last byte and backend_pick sampled on the byte that
//    completes the 34-byte header.
//  - Output channel (out_valid / out_stall / out_data) carries rewritten bytes with
//    the frame verdict and last_of_run on the final beat caused by one input beat.
//  - Header bytes are buffered; no output until byte 34 or the end of the frame.
//    Then the header burst goes out, a read and an output load per beat; a stall holds it.
//  - Header bytes are taken one per cycle. The burst: decide; for a rewritten
//    frame a checksum sweep, read and add per IPv4 byte, then FOLD1 and FOLD2;
//    then read and output per header byte; one read port and the accumulator set this.
//  - Payload bytes after the header pass through the output register: one per
//    cycle while the receiver keeps out_stall low.
//  - in_stall is high during the decide/sum/emit sequence and whenever a
//    pass-through byte would find the output register full and stalled.
//  - Reset clears the frame position, verdict and output valid, and restores the
//    configuration registers to their defaults. The header buffer is not cleared.
//  - Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write only
//    while the block is idle. Unknown indexes are ignored.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_tcp_balancer_header_rewrite (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire ihr_pkg::in_beat_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output ihr_pkg::out_beat_t                 out_data,
	input  wire logic                          cfg_we,
	input  wire logic [ihr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ihr_pkg::CFG_W-1:0]     cfg_wdata
);
	import ihr_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DECIDE   = 3'd1;
	localparam logic [2:0] ST_SUM_RD   = 3'd2;
	localparam logic [2:0] ST_SUM_ADD  = 3'd3;
	localparam logic [2:0] ST_FOLD1    = 3'd4;
	localparam logic [2:0] ST_FOLD2    = 3'd5;
	localparam logic [2:0] ST_EMIT_RD  = 3'd6;
	localparam logic [2:0] ST_EMIT_OUT = 3'd7;

	// header byte offsets
	localparam logic [IDX_W-1:0] OFS_DST_MAC_LO = 6'd5;
	localparam logic [IDX_W-1:0] OFS_SRC_MAC_LO = 6'd11;
	localparam logic [IDX_W-1:0] OFS_ETYPE_HI   = 6'd12;
	localparam logic [IDX_W-1:0] OFS_ETYPE_LO   = 6'd13;
	localparam logic [IDX_W-1:0] OFS_IP_START   = 6'd14;
	localparam logic [IDX_W-1:0] OFS_PROTO      = 6'd23;
	localparam logic [IDX_W-1:0] OFS_CSUM_HI    = 6'd24;
	localparam logic [IDX_W-1:0] OFS_CSUM_LO    = 6'd25;
	localparam logic [IDX_W-1:0] OFS_SRC_IP0    = 6'd26;
	localparam logic [IDX_W-1:0] OFS_SRC_IP1    = 6'd27;
	localparam logic [IDX_W-1:0] OFS_SRC_IP2    = 6'd28;
	localparam logic [IDX_W-1:0] OFS_SRC_IP3    = 6'd29;
	localparam logic [IDX_W-1:0] OFS_DST_IP0    = 6'd30;
	localparam logic [IDX_W-1:0] OFS_DST_IP1    = 6'd31;
	localparam logic [IDX_W-1:0] OFS_DST_IP2    = 6'd32;
	localparam logic [IDX_W-1:0] OFS_DST_IP3    = 6'd33;

	localparam logic [IDX_W-1:0] HDR_LEN = IDX_W'(HDR_BYTES);
	localparam logic [IDX_W-1:0] ETH_LEN = IDX_W'(ETH_BYTES);

	// new value of a header byte in a rewritten frame
	function automatic logic [7:0] hdr_subst(
		input logic [IDX_W-1:0] idx,
		input logic [7:0]       orig,
		input logic [23:0]      prefix,
		input logic [7:0]       dest,
		input logic [7:0]       lb,
		input logic [15:0]      csum
	);
		logic [7:0] res;
		case (idx)
			OFS_DST_MAC_LO: res = dest;
			OFS_SRC_MAC_LO: res = lb;
			OFS_CSUM_HI:    res = csum[15:8];
			OFS_CSUM_LO:    res = csum[7:0];
			OFS_SRC_IP0:    res = prefix[23:16];
			OFS_SRC_IP1:    res = prefix[15:8];
			OFS_SRC_IP2:    res = prefix[7:0];
			OFS_SRC_IP3:    res = lb;
			OFS_DST_IP0:    res = prefix[23:16];
			OFS_DST_IP1:    res = prefix[15:8];
			OFS_DST_IP2:    res = prefix[7:0];
			OFS_DST_IP3:    res = dest;
			default:        res = orig;
		endcase
		return res;
	endfunction

	// configuration
	logic [23:0] net_prefix_q;
	logic [7:0]  client_host_q;
	logic [7:0]  backend_a_host_q;
	logic [7:0]  backend_b_host_q;
	logic [7:0]  lb_host_q;

	// sequencer and frame state
	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;      // header bytes held, saturates at HDR_LEN
	logic [IDX_W-1:0] k_q;        // sweep position
	logic [1:0]       fverd_q;    // verdict for payload bytes
	logic [1:0]       verdict_q;  // verdict of the burst in progress
	logic [7:0]       dest_q;
	logic             eof_q;
	logic             pick_q;

	// header facts captured as bytes are written
	logic       etype_hi_ok_q;
	logic       etype_lo_ok_q;
	logic       tcp_ok_q;
	logic [3:0] src_ok_q;

	// header buffer
	logic [7:0] hdr_mem [HDR_BYTES];
	logic [7:0] rd_q;

	// output register
	logic      out_valid_q;
	out_beat_t out_data_q;

	logic       out_free;
	logic       hdr_phase;
	logic       in_acc;
	logic       hdr_acc;
	logic       pass_acc;
	logic       hdr_done;
	logic [IDX_W-1:0] idx_next;
	logic [1:0] dec_verdict;
	logic [7:0] dec_dest;
	logic       emit_load;
	logic       emit_last;
	logic [7:0] emit_byte;
	logic [7:0] sum_byte;
	logic [15:0] csum;
	csum_ctl_t  csum_ctl;

	assign out_free  = !out_valid_q || !out_stall;
	assign hdr_phase = idx_q < HDR_LEN;
	assign in_stall  = !((state_q == ST_IDLE) && (hdr_phase || out_free));
	assign in_acc    = in_valid && !in_stall;
	assign hdr_acc   = in_acc && hdr_phase;
	assign pass_acc  = in_acc && !hdr_phase;
	assign idx_next  = idx_q + 6'd1;
	assign hdr_done  = in_data.end_of_frame || (idx_next == HDR_LEN);

	// frame fate from the captured facts
	always_comb begin
		if (idx_q < ETH_LEN) begin
			dec_verdict = VERDICT_ABORT;
		end else if (!(etype_hi_ok_q && etype_lo_ok_q)) begin
			dec_verdict = VERDICT_PASS;
		end else if (idx_q < HDR_LEN) begin
			dec_verdict = VERDICT_ABORT;
		end else if (!tcp_ok_q) begin
			dec_verdict = VERDICT_PASS;
		end else begin
			dec_verdict = VERDICT_TX;
		end
		if (&src_ok_q) begin
			dec_dest = pick_q ? backend_b_host_q : backend_a_host_q;
		end else begin
			dec_dest = client_host_q;
		end
	end

	// checksum sweep sees the checksum field as zero
	assign sum_byte = hdr_subst(k_q, rd_q, net_prefix_q, dest_q, lb_host_q, 16'h0000);

	always_comb begin
		if (verdict_q == VERDICT_TX) begin
			emit_byte = hdr_subst(k_q, rd_q, net_prefix_q, dest_q, lb_host_q, csum);
		end else begin
			emit_byte = rd_q;
		end
	end

	assign emit_load = (state_q == ST_EMIT_OUT) && out_free;
	assign emit_last = (6'(k_q + 6'd1) == idx_q);

	always_comb begin
		csum_ctl.clr  = (state_q == ST_DECIDE);
		csum_ctl.add  = (state_q == ST_SUM_ADD);
		csum_ctl.hi   = !k_q[0];
		csum_ctl.fold = (state_q == ST_FOLD1) || (state_q == ST_FOLD2);
	end

	ihr_csum_acc u_csum (
		.clk      (clk),
		.ctl      (csum_ctl),
		.add_byte (sum_byte),
		.csum     (csum)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_prefix_q     <= 24'hAC1100;
			client_host_q    <= 8'd4;
			backend_a_host_q <= 8'd2;
			backend_b_host_q <= 8'd3;
			lb_host_q        <= 8'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NET_PREFIX: net_prefix_q     <= cfg_wdata;
				REG_CLIENT:     client_host_q    <= cfg_wdata[7:0];
				REG_BACKEND_A:  backend_a_host_q <= cfg_wdata[7:0];
				REG_BACKEND_B:  backend_b_host_q <= cfg_wdata[7:0];
				REG_LB:         lb_host_q        <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// header buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (hdr_acc) begin
			hdr_mem[idx_q] <= in_data.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM_RD || state_q == ST_EMIT_RD) begin
			rd_q <= hdr_mem[k_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			k_q           <= '0;
			fverd_q       <= VERDICT_ABORT;
			verdict_q     <= VERDICT_ABORT;
			dest_q        <= '0;
			eof_q         <= 1'b0;
			pick_q        <= 1'b0;
			etype_hi_ok_q <= 1'b0;
			etype_lo_ok_q <= 1'b0;
			tcp_ok_q      <= 1'b0;
			src_ok_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (hdr_acc) begin
						idx_q  <= idx_next;
						eof_q  <= in_data.end_of_frame;
						pick_q <= in_data.backend_pick;
						case (idx_q)
							OFS_ETYPE_HI:
								etype_hi_ok_q <= in_data.data_byte == ETHERTYPE_IPV4[15:8];
							OFS_ETYPE_LO:
								etype_lo_ok_q <= in_data.data_byte == ETHERTYPE_IPV4[7:0];
							OFS_PROTO:
								tcp_ok_q <= in_data.data_byte == PROTO_TCP;
							OFS_SRC_IP0:
								src_ok_q[0] <= in_data.data_byte == net_prefix_q[23:16];
							OFS_SRC_IP1:
								src_ok_q[1] <= in_data.data_byte == net_prefix_q[15:8];
							OFS_SRC_IP2:
								src_ok_q[2] <= in_data.data_byte == net_prefix_q[7:0];
							OFS_SRC_IP3:
								src_ok_q[3] <= in_data.data_byte == client_host_q;
							default: ;
						endcase
						if (hdr_done) begin
							state_q <= ST_DECIDE;
						end
					end else if (pass_acc && in_data.end_of_frame) begin
						idx_q   <= '0;
						fverd_q <= VERDICT_ABORT;
					end
				end
				ST_DECIDE: begin
					verdict_q <= dec_verdict;
					dest_q    <= dec_dest;
					if (dec_verdict == VERDICT_TX) begin
						k_q     <= OFS_IP_START;
						state_q <= ST_SUM_RD;
					end else begin
						k_q     <= '0;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_SUM_RD: begin
					state_q <= ST_SUM_ADD;
				end
				ST_SUM_ADD: begin
					if (k_q == OFS_DST_IP3) begin
						state_q <= ST_FOLD1;
					end else begin
						k_q     <= k_q + 6'd1;
						state_q <= ST_SUM_RD;
					end
				end
				ST_FOLD1: begin
					state_q <= ST_FOLD2;
				end
				ST_FOLD2: begin
					k_q     <= '0;
					state_q <= ST_EMIT_RD;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (emit_load) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
							if (eof_q) begin
								idx_q   <= '0;
								fverd_q <= VERDICT_ABORT;
							end else begin
								fverd_q <= verdict_q;
							end
						end else begin
							k_q     <= k_q + 6'd1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load || pass_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q.out_byte    <= emit_byte;
			out_data_q.verdict     <= verdict_q;
			out_data_q.last_of_run <= emit_last;
		end else if (pass_acc) begin
			out_data_q.out_byte    <= in_data.data_byte;
			out_data_q.verdict     <= fverd_q;
			out_data_q.last_of_run <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= HDR_LEN)
		else $error("header byte count overran the header length");

	a_sum_only_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM_RD) |-> (verdict_q == VERDICT_TX && idx_q == HDR_LEN))
		else $error("checksum sweep on a frame that is not rewritten");

	a_sum_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM_ADD) |-> (k_q >= OFS_IP_START && k_q <= OFS_DST_IP3))
		else $error("checksum sweep left the IPv4 header");

	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_last && eof_q) |=> (idx_q == '0 && state_q == ST_IDLE))
		else $error("frame end did not reset the header position");

endmodule
`default_nettype wire

FILE: rtl/core/ihr_csum_acc.sv
// One's-complement checksum accumulator, one byte per add step, folded at the end.
// Depends on ihr_pkg for the control struct and accumulator width.
`timescale 1ns / 1ps
`default_nettype none
module ihr_csum_acc (
	input  wire logic              clk,
	input  wire ihr_pkg::csum_ctl_t ctl,
	input  wire logic [7:0]        add_byte,
	output logic [15:0]            csum
);
	import ihr_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] addend;

	// even offsets carry the high byte of a 16-bit word
	assign addend = ctl.hi ? {4'h0, add_byte, 8'h00} : {12'h000, add_byte};

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			sum_q <= '0;
		end else if (ctl.add) begin
			sum_q <= sum_q + addend;
		end else if (ctl.fold) begin
			sum_q <= SUM_W'(sum_q[15:0]) + SUM_W'(sum_q[SUM_W-1:16]);
		end
	end

	assign csum = ~sum_q[15:0];

endmodule
`default_nettype wire

FILE: tb/sv/ihr_rewrite_checker.sv
// Scoreboard for the IPv4 TCP balancer header rewrite: snoops both beat channels and
// the register port, predicts every output beat and compares it field by field.
// Depends on ihr_pkg for the beat structs, verdict codes and register indexes.
`timescale 1ns / 1ps
module ihr_rewrite_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  ihr_pkg::in_beat_t             in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  ihr_pkg::out_beat_t            out_data,
	input  logic                          cfg_we,
	input  logic [ihr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ihr_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            fails,
	output int                            pending
);
	import ihr_pkg::*;

	// register copies, reset values as the block comes out of reset
	logic [23:0] prefix_r;
	logic [7:0]  client_r;
	logic [7:0]  bka_r;
	logic [7:0]  bkb_r;
	logic [7:0]  lb_r;

	logic [7:0]  hdr [HDR_BYTES];
	int          held;
	logic [1:0]  run_verdict;
	out_beat_t   owed_bytes [$];
	out_beat_t   due;

	function automatic logic [31:0] host_ip(input logic [7:0] host);
		return {prefix_r, host};
	endfunction

	// one accepted frame byte: hold it, or settle the header and queue its burst
	task automatic take_frame_byte(input in_beat_t b);
		out_beat_t   e;
		logic [1:0]  fate;
		logic [7:0]  dest;
		logic [31:0] sum;
		logic [15:0] csum;
		int          k;
		if (held >= HDR_BYTES) begin
			e.out_byte    = b.data_byte;
			e.verdict     = run_verdict;
			e.last_of_run = 1'b1;
			owed_bytes.push_back(e);
			if (b.end_of_frame) begin
				held        = 0;
				run_verdict = VERDICT_ABORT;
			end
			return;
		end
		hdr[held] = b.data_byte;
		held++;
		if (!b.end_of_frame && held < HDR_BYTES)
			return;

		if (held < ETH_BYTES)
			fate = VERDICT_ABORT;
		else if ({hdr[12], hdr[13]} != ETHERTYPE_IPV4)
			fate = VERDICT_PASS;
		else if (held < HDR_BYTES)
			fate = VERDICT_ABORT;
		else if (hdr[23] != PROTO_TCP)
			fate = VERDICT_PASS;
		else begin
			fate = VERDICT_TX;
			if ({hdr[26], hdr[27], hdr[28], hdr[29]} == host_ip(client_r))
				dest = b.backend_pick ? bkb_r : bka_r;
			else
				dest = client_r;
			{hdr[30], hdr[31], hdr[32], hdr[33]} = host_ip(dest);
			hdr[5] = dest;
			{hdr[26], hdr[27], hdr[28], hdr[29]} = host_ip(lb_r);
			hdr[11] = lb_r;
			// ones' complement sum over the 20-byte IP header, checksum word as zero
			sum = 32'h0;
			for (k = ETH_BYTES; k < HDR_BYTES; k += 2)
				if (k != 24)
					sum += {16'h0, hdr[k], hdr[k+1]};
			while (sum[31:16] != 16'h0)
				sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
			csum    = ~sum[15:0];
			hdr[24] = csum[15:8];
			hdr[25] = csum[7:0];
		end

		for (k = 0; k < held; k++) begin
			e.out_byte    = hdr[k];
			e.verdict     = fate;
			e.last_of_run = (k == held - 1);
			owed_bytes.push_back(e);
		end
		if (b.end_of_frame) begin
			held        = 0;
			run_verdict = VERDICT_ABORT;
		end else
			run_verdict = fate;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_bytes.delete();
			held        = 0;
			run_verdict = VERDICT_ABORT;
			prefix_r    = 24'hAC1100;
			client_r    = 8'd4;
			bka_r       = 8'd2;
			bkb_r       = 8'd3;
			lb_r        = 8'd5;
			fails       = 0;
			pending     = 0;
		end else begin
			// output first: a beat leaving now never stems from a byte taken now
			if (out_valid && !out_stall) begin
				if (owed_bytes.size() == 0) begin
					$error("unexpected output beat, out_byte %0h", out_data.out_byte);
					fails++;
				end else begin
					due = owed_bytes.pop_front();
					if (out_data.out_byte !== due.out_byte) begin
						$error("out_byte: expected %0h, got %0h",
							due.out_byte, out_data.out_byte);
						fails++;
					end
					if (out_data.verdict !== due.verdict) begin
						$error("verdict: expected %0d, got %0d",
							due.verdict, out_data.verdict);
						fails++;
					end
					if (out_data.last_of_run !== due.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b",
							due.last_of_run, out_data.last_of_run);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall)
				take_frame_byte(in_data);
			if (cfg_we) begin
				case (cfg_index)
					REG_NET_PREFIX: prefix_r = cfg_wdata;
					REG_CLIENT:     client_r = cfg_wdata[7:0];
					REG_BACKEND_A:  bka_r    = cfg_wdata[7:0];
					REG_BACKEND_B:  bkb_r    = cfg_wdata[7:0];
					REG_LB:         lb_r     = cfg_wdata[7:0];
					default: ;
				endcase
			end
			pending = owed_bytes.size();
		end
	end

endmodule

FILE: tb/sv/ipv4_tcp_balancer_header_rewrite_test.sv
// Top of the header rewrite testbench: clock, reset, frame stimulus, register writes
// and the final verdict. Needs ihr_pkg, the block itself and ihr_rewrite_checker.
`timescale 1ns / 1ps
module ipv4_tcp_balancer_header_rewrite_test;
	import ihr_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 11;
	// header burst worst case: decide, checksum sweep, fold and emit of a full header, rounded up
	localparam int SETTLE_CYCLES = 128;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int PHASE_BYTES   = 12;
	// watchdog bound for the whole run; leave plenty of margin over the slowest legal run
	localparam int CYCLE_LIMIT   = 200000;

	typedef enum int {
		FK_SHORT,        // ends inside the Ethernet header
		FK_ALIEN_TYPE,   // EtherType other than IPv4
		FK_SHORT_IP,     // IPv4 ending inside the IP header
		FK_ALIEN_PROTO,  // full IPv4 header, protocol other than TCP
		FK_TCP_CLIENT,   // TCP sourced by the client: goes to a backend
		FK_TCP_OTHER     // TCP from anyone else: goes to the client
	} frame_kind_e;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_beat_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_beat_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	int chk_fails;
	int chk_pending;
	int cycle_count;
	int bytes_sent;

	// knobs shared between the sender and the receiver
	bit tx_idle_on;
	bit rx_idle_on;
	bit rx_hold_req;

	// what the block currently thinks the network looks like; needed to forge
	// frames that really come from the client
	logic [23:0] prefix_now;
	logic [7:0]  client_now;

	logic [7:0] frame_q [$];

	ipv4_tcp_balancer_header_rewrite dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ihr_rewrite_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.fails     (chk_fails),
		.pending   (chk_pending)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		cycle_count = 0;
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Receiver: draws a stall length per beat; on request it holds off for a long
	// stretch so the header burst backs up and the block stalls its input.
	initial begin : receiver
		int wait_n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				out_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			wait_n = rx_idle_on ? $urandom_range(0, 5) : 0;
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid && !rx_hold_req);
			@(negedge clk);
		end
	end

	// Drop valid and wait until every predicted beat has left, then give the
	// block time to finish any internal work before registers change.
	task automatic settle();
		in_valid <= 1'b0;
		while (chk_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_wdata <= val;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_NET_PREFIX: prefix_now = val;
			REG_CLIENT:     client_now = val[7:0];
			default: ;
		endcase
	endtask

	// all five registers, plus junk to the unused indexes which must be ignored
	task automatic load_setting(input logic [23:0] prefix, input logic [7:0] client,
			input logic [7:0] bka, input logic [7:0] bkb, input logic [7:0] lb);
		int i;
		settle();
		write_reg(REG_NET_PREFIX, prefix);
		write_reg(REG_CLIENT, {16'h0, client});
		write_reg(REG_BACKEND_A, {16'h0, bka});
		write_reg(REG_BACKEND_B, {16'h0, bkb});
		write_reg(REG_LB, {16'h0, lb});
		for (i = REG_LB + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
	endtask

	task automatic build_frame(input frame_kind_e kind, input int len);
		int          i;
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [23:0] flip;
		frame_q.delete();
		for (i = 0; i < len; i++)
			frame_q.push_back(8'($urandom));

		etype = ETHERTYPE_IPV4;
		if (kind == FK_ALIEN_TYPE) begin
			case ($urandom_range(0, 5))
				0: etype = 16'h0801;
				1: etype = 16'h0008;   // byte-swapped IPv4
				2: etype = 16'h0000;
				3: etype = 16'hFFFF;
				4: etype = 16'h86DD;
				default: begin
					etype = 16'($urandom);
					if (etype == ETHERTYPE_IPV4)
						etype = 16'h0C00;
				end
			endcase
		end

		proto = PROTO_TCP;
		if (kind == FK_ALIEN_PROTO) begin
			case ($urandom_range(0, 4))
				0: proto = PROTO_TCP + 8'd1;
				1: proto = 8'h00;
				2: proto = 8'hFF;
				3: proto = 8'd17;
				default: begin
					proto = 8'($urandom);
					if (proto == PROTO_TCP)
						proto = 8'h86;
				end
			endcase
		end

		src = 32'($urandom);
		if (kind == FK_TCP_CLIENT)
			src = {prefix_now, client_now};
		else if (kind == FK_TCP_OTHER) begin
			// near misses: right subnet wrong host, or client host in another subnet
			flip = 24'(8'($urandom_range(1, 255))) << (8 * $urandom_range(0, 2));
			case ($urandom_range(0, 2))
				0: src = {prefix_now, client_now + 8'($urandom_range(1, 255))};
				1: src = {prefix_now ^ flip, client_now};
				default: ;
			endcase
		end

		if (kind != FK_SHORT) begin
			frame_q[12] = etype[15:8];
			frame_q[13] = etype[7:0];
		end
		if (kind != FK_SHORT && kind != FK_ALIEN_TYPE && len > 23)
			frame_q[23] = proto;
		if (kind == FK_TCP_CLIENT || kind == FK_TCP_OTHER)
			{frame_q[26], frame_q[27], frame_q[28], frame_q[29]} = src;
	endtask

	// pick_hdr lands on the byte that completes the header; elsewhere the bit is noise
	task automatic send_frame(input logic pick_hdr);
		in_beat_t b;
		int       i;
		int       gap;
		for (i = 0; i < frame_q.size(); i++) begin
			b.data_byte    = frame_q[i];
			b.end_of_frame = (i == frame_q.size() - 1);
			b.backend_pick = (i == HDR_BYTES - 1) ? pick_hdr : 1'($urandom_range(0, 1));
			gap = tx_idle_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_data  <= b;
			in_valid <= 1'b1;
			do
				@(posedge clk);
			while (in_stall);
			@(negedge clk);
		end
		bytes_sent += frame_q.size();
	endtask

	// Mostly well-formed TCP frames, which exercise the rewrite; the rest are the
	// abort and pass-through shapes. Payload is short with an occasional long tail.
	task automatic random_frames(input int budget);
		int          start;
		int          len;
		frame_kind_e kind;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			case ($urandom_range(0, 9))
				0:       kind = FK_SHORT;
				1:       kind = FK_ALIEN_TYPE;
				2:       kind = FK_SHORT_IP;
				3:       kind = FK_ALIEN_PROTO;
				4, 5, 6: kind = FK_TCP_CLIENT;
				default: kind = FK_TCP_OTHER;
			endcase
			case (kind)
				FK_SHORT:       len = $urandom_range(1, ETH_BYTES - 1);
				FK_ALIEN_TYPE:  len = $urandom_range(ETH_BYTES, HDR_BYTES + 8);
				FK_SHORT_IP:    len = $urandom_range(ETH_BYTES, HDR_BYTES - 1);
				FK_ALIEN_PROTO: len = HDR_BYTES + $urandom_range(0, 8);
				default:
					len = HDR_BYTES + (($urandom_range(0, 4) == 0) ?
						$urandom_range(7, 24) : $urandom_range(0, 6));
			endcase
			// some frames run back to back on both sides
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			build_frame(kind, len);
			send_frame(1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : stimulus
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		bytes_sent  = 0;
		tx_idle_on  = 1'b1;
		rx_idle_on  = 1'b1;
		rx_hold_req = 1'b0;
		prefix_now  = 24'hAC1100;
		client_now  = 8'd4;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under reset settings: one of each fate at the length edges.
		build_frame(FK_SHORT, 1);
		frame_q[0] = 8'hFF;
		send_frame(1'b0);
		build_frame(FK_SHORT, ETH_BYTES - 1);
		foreach (frame_q[i])
			frame_q[i] = 8'h00;
		send_frame(1'b0);
		build_frame(FK_ALIEN_TYPE, ETH_BYTES);
		send_frame(1'b1);
		build_frame(FK_SHORT_IP, HDR_BYTES - 1);
		send_frame(1'b0);
		build_frame(FK_ALIEN_PROTO, HDR_BYTES);
		send_frame(1'b1);
		build_frame(FK_TCP_CLIENT, HDR_BYTES);
		send_frame(1'b0);
		build_frame(FK_TCP_CLIENT, HDR_BYTES + 2);
		send_frame(1'b1);
		build_frame(FK_TCP_OTHER, HDR_BYTES + 1);
		send_frame(1'b1);

		random_frames(PHASE_BYTES);

		load_setting(24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		random_frames(PHASE_BYTES);

		// low extreme: everything zero, so client and backends coincide
		load_setting(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00);
		random_frames(PHASE_BYTES);

		load_setting(24'hFFFFFF, 8'hFF, 8'hFE, 8'h00, 8'hFF);
		random_frames(PHASE_BYTES);

		// Back-pressure: receiver goes quiet while the sender keeps pushing a long
		// rewritten frame, so the burst stalls and in_stall has to hold the input.
		load_setting(24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		tx_idle_on  = 1'b0;
		rx_hold_req = 1'b1;
		build_frame(FK_TCP_CLIENT, HDR_BYTES + 12);
		send_frame(1'($urandom_range(0, 1)));
		random_frames(PHASE_BYTES);

		settle();
		if (chk_fails == 0 && chk_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
